### rtl/stip_pkg.sv
// Shared constants and codes for the setpoint table interpolator.
// No dependencies; every other file in rtl/ uses this package.
package stip_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int ADC_BITS_DEF   = 12;
    localparam int SET_W          = 14;
    localparam int COUNT_W        = 5;
    localparam int SLOT_W         = 4;

    typedef logic [1:0] op_t;

    localparam op_t OP_WRITE     = 2'd0;
    localparam op_t OP_CALIBRATE = 2'd1;
    localparam op_t OP_MAP       = 2'd2;
    localparam op_t OP_NEAREST   = 2'd3;

endpackage

### rtl/setpoint_table_interpolator.sv
// Setpoint table interpolator: one request at a time; the table scan reads one entry a cycle.
// A write, or any request on an empty table, goes straight to evaluation; calibrate, nearest
// and map scan the table first, and map adds a multiply and a divide when it interpolates.
// The next request is taken the cycle after the result is loaded into the output register.
// Reset (rst_n, async) clears all table valid bits, so every entry reads zero; point_count 0.
// Depends on stip_pkg, stip_ram and stip_div.
module setpoint_table_interpolator #(
    parameter int MAX_POINTS = stip_pkg::MAX_POINTS_DEF,
    parameter int ADC_BITS   = stip_pkg::ADC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         config_write_enable,
    input  logic [stip_pkg::COUNT_W-1:0] config_write_data,
    input  logic                         request_valid,
    output logic                         request_stall,
    input  stip_pkg::op_t                operation,
    input  logic [stip_pkg::SLOT_W-1:0]  entry_index,
    input  logic [stip_pkg::SET_W-1:0]   setting,
    input  logic [ADC_BITS-1:0]          adc_value,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [ADC_BITS-1:0]          mapped_adc,
    output logic [stip_pkg::SLOT_W-1:0]  nearest_index,
    output logic                         error,
    output logic                         adc_in_range
);

    import stip_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PROD_W = SET_W + ADC_BITS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PRE    = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_WAIT   = 4'd3;
    localparam logic [3:0] ST_EVAL   = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_DSTART = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                  tag_vld_reg, tag_vld_next;
    logic                  tag_pre_reg, tag_pre_next;
    logic [IDX_W-1:0]      tag_idx_reg, tag_idx_next;
    logic [MAX_POINTS-1:0] vld_reg, vld_next;
    logic [COUNT_W-1:0]    point_count_reg, point_count_next;
    logic                  result_valid_reg, result_valid_next;
    logic                  ex_found_reg, ex_found_next;
    logic                  hit_found_reg, hit_found_next;

    op_t                   op_reg, op_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [ADC_BITS-1:0]   adc_reg, adc_next;
    logic [SET_W-1:0]      first_set_reg, first_set_next;
    logic [ADC_BITS-1:0]   first_adc_reg, first_adc_next;
    logic [SET_W-1:0]      last_set_reg, last_set_next;
    logic [ADC_BITS-1:0]   last_adc_reg, last_adc_next;
    logic [SET_W-1:0]      prev_set_reg, prev_set_next;
    logic [ADC_BITS-1:0]   prev_adc_reg, prev_adc_next;
    logic [IDX_W-1:0]      ex_idx_reg, ex_idx_next;
    logic [ADC_BITS-1:0]   ex_adc_reg, ex_adc_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic                  hit_last_reg, hit_last_next;
    logic [SET_W-1:0]      hit_set_reg, hit_set_next;
    logic [ADC_BITS-1:0]   hit_adc_reg, hit_adc_next;
    logic [SET_W-1:0]      hit_nset_reg, hit_nset_next;
    logic [ADC_BITS-1:0]   hit_nadc_reg, hit_nadc_next;
    logic [SET_W-1:0]      ds_reg, ds_next;
    logic [SET_W-1:0]      den_reg, den_next;
    logic [ADC_BITS-1:0]   mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ADC_BITS-1:0]   pend_mapped_reg, pend_mapped_next;
    logic [IDX_W-1:0]      pend_near_reg, pend_near_next;
    logic                  pend_err_reg, pend_err_next;
    logic                  pend_inr_reg, pend_inr_next;
    logic [ADC_BITS-1:0]   mapped_reg, mapped_next;
    logic [SLOT_W-1:0]     near_reg, near_next;
    logic                  err_reg, err_next;
    logic                  inr_reg, inr_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [SET_W-1:0]      ram_qset;
    logic [ADC_BITS-1:0]   ram_qadc;
    logic [SET_W-1:0]      rd_set;
    logic [ADC_BITS-1:0]   rd_adc;

    logic                  div_start;
    logic                  div_done;
    logic [ADC_BITS-1:0]   div_quo;

    logic                  accept;
    logic [CNT_W-1:0]      n_val;
    logic [IDX_W-1:0]      last_idx;
    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_addr;
    logic                  at_last;
    logic [ADC_BITS-1:0]   cur_last_adc;
    logic                  asc_c;
    logic                  hit_c;
    logic                  range_ok;
    logic                  map_fail;
    logic                  inr_c;
    logic [ADC_BITS-1:0]   db_c;
    logic [ADC_BITS-1:0]   da_c;
    logic [IDX_W-1:0]      near_idx_c;

    assign request_stall = state_reg != ST_IDLE;
    assign accept        = request_valid && !request_stall;

    assign n_val     = (32'(point_count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                           : CNT_W'(point_count_reg);
    assign last_idx  = IDX_W'(n_val - CNT_W'(1));
    assign slot_ok   = 32'(slot_reg) < MAX_POINTS;
    assign slot_addr = IDX_W'(slot_reg);

    assign rd_set = vld_reg[tag_idx_reg] ? ram_qset : '0;
    assign rd_adc = vld_reg[tag_idx_reg] ? ram_qadc : '0;

    assign at_last      = tag_idx_reg == last_idx;
    assign cur_last_adc = at_last ? rd_adc : last_adc_reg;
    assign asc_c        = first_adc_reg < cur_last_adc;
    assign hit_c        = (op_reg == OP_MAP) ? (rd_set < set_reg)
                        : (asc_c ? (rd_adc < adc_reg) : (rd_adc > adc_reg));

    assign range_ok = (first_set_reg <= set_reg && set_reg <= last_set_reg)
                   || (last_set_reg <= set_reg && set_reg <= first_set_reg);
    assign map_fail = (n_val < CNT_W'(2)) || !range_ok || !hit_found_reg || hit_last_reg
                   || (hit_nset_reg <= hit_set_reg);

    assign inr_c = (n_val != '0)
                && ((first_adc_reg <= adc_reg && adc_reg <= last_adc_reg)
                 || (last_adc_reg <= adc_reg && adc_reg <= first_adc_reg));

    assign db_c = (adc_reg >= hit_adc_reg) ? adc_reg - hit_adc_reg : hit_adc_reg - adc_reg;
    assign da_c = (hit_nadc_reg >= adc_reg) ? hit_nadc_reg - adc_reg : adc_reg - hit_nadc_reg;

    always_comb
    begin
        priority if (!hit_found_reg)
        begin
            near_idx_c = '0;
        end
        else if (hit_last_reg || db_c < da_c)
        begin
            near_idx_c = hit_idx_reg;
        end
        else
        begin
            near_idx_c = hit_idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        issue_idx_next    = issue_idx_reg;
        tag_vld_next      = 1'b0;
        tag_pre_next      = 1'b0;
        tag_idx_next      = tag_idx_reg;
        vld_next          = vld_reg;
        point_count_next  = point_count_reg;
        result_valid_next = result_valid_reg;
        ex_found_next     = ex_found_reg;
        hit_found_next    = hit_found_reg;
        op_next           = op_reg;
        slot_next         = slot_reg;
        set_next          = set_reg;
        adc_next          = adc_reg;
        first_set_next    = first_set_reg;
        first_adc_next    = first_adc_reg;
        last_set_next     = last_set_reg;
        last_adc_next     = last_adc_reg;
        prev_set_next     = prev_set_reg;
        prev_adc_next     = prev_adc_reg;
        ex_idx_next       = ex_idx_reg;
        ex_adc_next       = ex_adc_reg;
        hit_idx_next      = hit_idx_reg;
        hit_last_next     = hit_last_reg;
        hit_set_next      = hit_set_reg;
        hit_adc_next      = hit_adc_reg;
        hit_nset_next     = hit_nset_reg;
        hit_nadc_next     = hit_nadc_reg;
        ds_next           = ds_reg;
        den_next          = den_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        prod_next         = prod_reg;
        pend_mapped_next  = pend_mapped_reg;
        pend_near_next    = pend_near_reg;
        pend_err_next     = pend_err_reg;
        pend_inr_next     = pend_inr_reg;
        mapped_next       = mapped_reg;
        near_next         = near_reg;
        err_next          = err_reg;
        inr_next          = inr_reg;
        ram_we            = 1'b0;
        ram_waddr         = slot_addr;
        ram_raddr         = issue_idx_reg;
        div_start         = 1'b0;

        if (config_write_enable)
        begin
            point_count_next = config_write_data;
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        // fold in the entry read last cycle
        if (tag_vld_reg)
        begin
            if (tag_pre_reg)
            begin
                first_set_next = rd_set;
                first_adc_next = rd_adc;
            end
            else
            begin
                if (at_last)
                begin
                    last_set_next = rd_set;
                    last_adc_next = rd_adc;
                end
                prev_set_next = rd_set;
                prev_adc_next = rd_adc;
                if (!ex_found_reg && rd_set == set_reg)
                begin
                    ex_found_next = 1'b1;
                    ex_idx_next   = tag_idx_reg;
                    ex_adc_next   = rd_adc;
                end
                if (!hit_found_reg && hit_c)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = tag_idx_reg;
                    hit_last_next  = at_last;
                    hit_set_next   = rd_set;
                    hit_adc_next   = rd_adc;
                    hit_nset_next  = prev_set_reg;
                    hit_nadc_next  = prev_adc_reg;
                end
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = operation;
                    slot_next      = entry_index;
                    set_next       = setting;
                    adc_next       = adc_value;
                    ex_found_next  = 1'b0;
                    hit_found_next = 1'b0;
                    if (operation == OP_WRITE || n_val == '0)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_PRE;
                    end
                end
            end
            ST_PRE:
            begin
                ram_raddr      = '0;
                tag_vld_next   = 1'b1;
                tag_pre_next   = 1'b1;
                tag_idx_next   = '0;
                issue_idx_next = last_idx;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                ram_raddr      = issue_idx_reg;
                tag_vld_next   = 1'b1;
                tag_idx_next   = issue_idx_reg;
                issue_idx_next = issue_idx_reg - IDX_W'(1);
                if (issue_idx_reg == '0)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                pend_mapped_next = '0;
                pend_near_next   = '0;
                pend_err_next    = 1'b0;
                pend_inr_next    = 1'b0;
                state_next       = ST_DONE;
                unique case (op_reg)
                    OP_WRITE:
                    begin
                        if (slot_ok)
                        begin
                            ram_we              = 1'b1;
                            ram_waddr           = slot_addr;
                            vld_next[slot_addr] = 1'b1;
                        end
                    end
                    OP_CALIBRATE:
                    begin
                        pend_err_next = !ex_found_reg;
                        if (ex_found_reg)
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = ex_idx_reg;
                            vld_next[ex_idx_reg] = 1'b1;
                        end
                    end
                    OP_MAP:
                    begin
                        if (ex_found_reg)
                        begin
                            pend_mapped_next = ex_adc_reg;
                        end
                        else if (map_fail)
                        begin
                            pend_err_next = 1'b1;
                        end
                        else
                        begin
                            ds_next    = set_reg - hit_set_reg;
                            den_next   = hit_nset_reg - hit_set_reg;
                            neg_next   = hit_nadc_reg < hit_adc_reg;
                            mag_next   = (hit_nadc_reg < hit_adc_reg)
                                       ? hit_adc_reg - hit_nadc_reg
                                       : hit_nadc_reg - hit_adc_reg;
                            state_next = ST_MUL;
                        end
                    end
                    OP_NEAREST:
                    begin
                        pend_near_next = near_idx_c;
                        pend_inr_next  = inr_c;
                    end
                endcase
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(ds_reg) * PROD_W'(mag_reg);
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    pend_mapped_next = neg_reg ? hit_adc_reg - div_quo : hit_adc_reg + div_quo;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    mapped_next       = pend_mapped_reg;
                    near_next         = SLOT_W'(pend_near_reg);
                    err_next          = pend_err_reg;
                    inr_next          = pend_inr_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_idx_reg    <= '0;
            tag_vld_reg      <= 1'b0;
            tag_pre_reg      <= 1'b0;
            tag_idx_reg      <= '0;
            vld_reg          <= '0;
            point_count_reg  <= '0;
            result_valid_reg <= 1'b0;
            ex_found_reg     <= 1'b0;
            hit_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_idx_reg    <= issue_idx_next;
            tag_vld_reg      <= tag_vld_next;
            tag_pre_reg      <= tag_pre_next;
            tag_idx_reg      <= tag_idx_next;
            vld_reg          <= vld_next;
            point_count_reg  <= point_count_next;
            result_valid_reg <= result_valid_next;
            ex_found_reg     <= ex_found_next;
            hit_found_reg    <= hit_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        slot_reg        <= slot_next;
        set_reg         <= set_next;
        adc_reg         <= adc_next;
        first_set_reg   <= first_set_next;
        first_adc_reg   <= first_adc_next;
        last_set_reg    <= last_set_next;
        last_adc_reg    <= last_adc_next;
        prev_set_reg    <= prev_set_next;
        prev_adc_reg    <= prev_adc_next;
        ex_idx_reg      <= ex_idx_next;
        ex_adc_reg      <= ex_adc_next;
        hit_idx_reg     <= hit_idx_next;
        hit_last_reg    <= hit_last_next;
        hit_set_reg     <= hit_set_next;
        hit_adc_reg     <= hit_adc_next;
        hit_nset_reg    <= hit_nset_next;
        hit_nadc_reg    <= hit_nadc_next;
        ds_reg          <= ds_next;
        den_reg         <= den_next;
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        prod_reg        <= prod_next;
        pend_mapped_reg <= pend_mapped_next;
        pend_near_reg   <= pend_near_next;
        pend_err_reg    <= pend_err_next;
        pend_inr_reg    <= pend_inr_next;
        mapped_reg      <= mapped_next;
        near_reg        <= near_next;
        err_reg         <= err_next;
        inr_reg         <= inr_next;
    end

    stip_ram #(
        .WIDTH (SET_W),
        .DEPTH (MAX_POINTS)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (set_reg),
        .raddr (ram_raddr),
        .rdata (ram_qset)
    );

    stip_ram #(
        .WIDTH (ADC_BITS),
        .DEPTH (MAX_POINTS)
    ) u_adc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (adc_reg),
        .raddr (ram_raddr),
        .rdata (ram_qadc)
    );

    stip_div #(
        .NUM_W (PROD_W),
        .DEN_W (SET_W),
        .Q_W   (ADC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (prod_reg),
        .den      (den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result_valid  = result_valid_reg;
    assign mapped_adc    = mapped_reg;
    assign nearest_index = near_reg;
    assign error         = err_reg;
    assign adc_in_range  = inr_reg;

endmodule

### rtl/stip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on stip_pkg for default sizes only.
module stip_ram #(
    parameter int WIDTH = stip_pkg::SET_W,
    parameter int DEPTH = stip_pkg::MAX_POINTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/stip_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Needs the quotient below 2**Q_W; depends on stip_pkg for default sizes.
module stip_div #(
    parameter int NUM_W = stip_pkg::SET_W + stip_pkg::ADC_BITS_DEF,
    parameter int DEN_W = stip_pkg::SET_W,
    parameter int Q_W   = stip_pkg::ADC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W);
            rem_next  = DEN_W'(num >> Q_W);
            quo_next  = num[Q_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/stip_checker.sv
// Port-level checks for setpoint_table_interpolator, attached by the bind below.
// Depends on stip_pkg and on the top level's port names.
module stip_checker #(
    parameter int ADC_BITS = stip_pkg::ADC_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        request_valid,
    input logic                        request_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [ADC_BITS-1:0]         mapped_adc,
    input logic [stip_pkg::SLOT_W-1:0] nearest_index,
    input logic                        error,
    input logic                        adc_in_range
);

    import stip_pkg::*;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall |=> request_stall)
        else $error("block took a request but did not go busy");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(mapped_adc)
            && $stable(nearest_index) && $stable(error) && $stable(adc_in_range))
        else $error("stalled result changed or dropped");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(request_stall))
        else $error("result appeared while no request was in progress");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error |-> mapped_adc == '0 && nearest_index == '0 && !adc_in_range)
        else $error("error result carries nonzero fields");

    a_nearest_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (nearest_index != '0 || adc_in_range) |-> mapped_adc == '0 && !error)
        else $error("nearest result mixed with map or error fields");

endmodule

bind setpoint_table_interpolator stip_checker #(.ADC_BITS(ADC_BITS)) u_stip_checker (.*);

### verif/tb_setpoint_table_interpolator.sv
// Self-checking testbench for setpoint_table_interpolator: random request gaps and result
// stalls, an in-bench prediction of every response, and random tables of calibration points.
// Depends on stip_pkg and the RTL of the block.
module tb_setpoint_table_interpolator;
    timeunit 1ns;
    timeprecision 1ps;
    import stip_pkg::*;

    localparam int POINTS         = 16;
    localparam int SET_MAX        = 9999;
    localparam int ADC_MAX        = 4095;
    localparam int STUCK_LIMIT    = 2000;
    localparam int REQUEST_TARGET = 1750;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [11:0] mapped;
        logic [3:0]  nearest;
        logic        error;
        logic        in_range;
    } lookup_reply_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                config_write_enable;
    logic [COUNT_W-1:0]  config_write_data;
    logic                request_valid;
    logic                request_stall;
    op_t                 operation;
    logic [SLOT_W-1:0]   entry_index;
    logic [SET_W-1:0]    setting;
    logic [11:0]         adc_value;
    logic                result_valid;
    logic                result_stall;
    logic [11:0]         mapped_adc;
    logic [SLOT_W-1:0]   nearest_index;
    logic                error;
    logic                adc_in_range;

    logic [SET_W-1:0]    shadow_setting [POINTS];
    logic [11:0]         shadow_adc [POINTS];
    logic [COUNT_W-1:0]  shadow_count;
    lookup_reply_t       awaited_replies [$];
    lookup_reply_t       want_reply;

    int requests_sent;
    int replies_checked;
    int error_replies;
    int mismatches;
    int count_settings;
    int op_count [4];
    int stall_hold;
    int stuck_cycles;
    bit quiet_stretch;

    setpoint_table_interpolator DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .config_write_enable (config_write_enable),
        .config_write_data   (config_write_data),
        .request_valid       (request_valid),
        .request_stall       (request_stall),
        .operation           (operation),
        .entry_index         (entry_index),
        .setting             (setting),
        .adc_value           (adc_value),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .mapped_adc          (mapped_adc),
        .nearest_index       (nearest_index),
        .error               (error),
        .adc_in_range        (adc_in_range)
    );

    always #4 clk = ~clk;

    function automatic int clamp(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int find_setting(input int n, input logic [SET_W-1:0] s);
        for (int i = n - 1; i >= 0; i--)
            if (shadow_setting[i] == s)
                return i;
        return -1;
    endfunction

    // Update the point store and work out the response of one accepted request.
    function automatic lookup_reply_t apply_request(input op_t op, input logic [3:0] slot,
            input logic [SET_W-1:0] s, input logic [11:0] a);
        lookup_reply_t r;
        int n;
        int hit;
        int k;
        bit ascending;
        longint lo_set;
        longint lo_adc;
        longint hi_set;
        longint hi_adc;
        longint d_lo;
        longint d_hi;
        longint v;
        r = '0;
        n = (shadow_count > POINTS) ? POINTS : int'(shadow_count);
        hit = find_setting(n, s);
        k = -1;
        case (op)
            OP_WRITE:
            begin
                shadow_setting[slot] = s;
                shadow_adc[slot] = a;
            end
            OP_CALIBRATE:
            begin
                if (hit >= 0)
                    shadow_adc[hit] = a;
                else
                    r.error = 1'b1;
            end
            OP_MAP:
            begin
                if (hit >= 0)
                    r.mapped = shadow_adc[hit];
                else
                begin
                    r.error = 1'b1;
                    if (n >= 2 && ((shadow_setting[0] <= s && s <= shadow_setting[n-1]) ||
                                   (shadow_setting[n-1] <= s && s <= shadow_setting[0])))
                        for (int i = n - 1; i >= 0 && k < 0; i--)
                            if (shadow_setting[i] < s)
                                k = i;
                    if (k >= 0 && k + 1 < n && shadow_setting[k+1] > shadow_setting[k])
                    begin
                        lo_set = longint'(shadow_setting[k]);
                        lo_adc = longint'(shadow_adc[k]);
                        hi_set = longint'(shadow_setting[k+1]);
                        hi_adc = longint'(shadow_adc[k+1]);
                        v = lo_adc + ((longint'(s) - lo_set) * (hi_adc - lo_adc)) /
                            (hi_set - lo_set);
                        if (v < 0)
                            v = 0;
                        r.error = 1'b0;
                        r.mapped = v[11:0];
                    end
                end
            end
            default:
            begin
                if (n > 0)
                begin
                    lo_adc = longint'(shadow_adc[0]);
                    hi_adc = longint'(shadow_adc[n-1]);
                    r.in_range = (lo_adc <= longint'(a) && longint'(a) <= hi_adc) ||
                                 (hi_adc <= longint'(a) && longint'(a) <= lo_adc);
                    ascending = lo_adc < hi_adc;
                    for (int i = n - 1; i >= 0 && k < 0; i--)
                        if (ascending ? shadow_adc[i] < a : shadow_adc[i] > a)
                            k = i;
                    if (k >= 0 && k + 1 >= n)
                        r.nearest = 4'(k);
                    else if (k >= 0)
                    begin
                        d_lo = longint'(a) - longint'(shadow_adc[k]);
                        if (d_lo < 0)
                            d_lo = -d_lo;
                        d_hi = longint'(shadow_adc[k+1]) - longint'(a);
                        if (d_hi < 0)
                            d_hi = -d_hi;
                        r.nearest = (d_lo < d_hi) ? 4'(k) : 4'(k + 1);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Enter and leave at a falling edge; the request stays valid for a back-to-back follower.
    task automatic send_request(input op_t op, input int slot, input int s, input int a);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 49) == 0)
            quiet_stretch = !quiet_stretch;
        if (gap > 0)
        begin
            request_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation = op;
        entry_index = 4'(slot);
        setting = 14'(s);
        adc_value = 12'(a);
        request_valid = 1'b1;
        do
            @(posedge clk);
        while (request_stall);
        awaited_replies.push_back(apply_request(op, entry_index, setting, adc_value));
        op_count[op]++;
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic load_point_count(input int value);
        request_valid = 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
        config_write_data = 5'(value);
        config_write_enable = 1'b1;
        @(negedge clk);
        config_write_enable = 1'b0;
        shadow_count = 5'(value);
        count_settings++;
    endtask

    task automatic test_empty_table();
        load_point_count(0);
        send_request(OP_CALIBRATE, 15, SET_MAX, ADC_MAX);
        send_request(OP_MAP, 0, 0, 0);
        send_request(OP_NEAREST, 15, SET_MAX, ADC_MAX);
    endtask

    task automatic test_directed_points();
        send_request(OP_WRITE, 0, 100, 200);
        send_request(OP_WRITE, 1, 200, 1000);
        send_request(OP_WRITE, 2, 200, 1200);
        send_request(OP_WRITE, 3, SET_MAX, ADC_MAX);
        send_request(OP_WRITE, 15, 0, 0);
        load_point_count(4);
        send_request(OP_MAP, 0, 200, 0);
        send_request(OP_MAP, 0, 150, 0);
        send_request(OP_MAP, 0, 50, 0);
        send_request(OP_MAP, 0, 5000, 0);
        send_request(OP_CALIBRATE, 0, 200, 1100);
        send_request(OP_CALIBRATE, 0, 300, 7);
        send_request(OP_NEAREST, 0, 0, 0);
        send_request(OP_NEAREST, 0, 0, ADC_MAX);
        send_request(OP_NEAREST, 0, 0, 600);
        load_point_count(1);
        send_request(OP_MAP, 0, 150, 0);
        send_request(OP_MAP, 0, 100, 0);
        load_point_count(31);
        send_request(OP_NEAREST, 0, 0, 2000);
        send_request(OP_MAP, 0, 100, 0);
        load_point_count(16);
        send_request(OP_MAP, 0, 50, 0);
    endtask

    task automatic fill_points(input int n);
        int shape;
        bit reversed;
        int cur_set;
        int cur_adc;
        int a;
        shape = $urandom_range(0, 2);
        reversed = ($urandom_range(0, 7) == 0);
        cur_set = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
        cur_adc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
        for (int i = 0; i < n; i++)
        begin
            a = (shape == 2) ? $urandom_range(0, ADC_MAX) :
                (shape == 1) ? ADC_MAX - cur_adc : cur_adc;
            send_request(OP_WRITE, reversed ? n - 1 - i : i, cur_set, a);
            if ($urandom_range(0, 9) != 0)
                cur_set = clamp(cur_set + $urandom_range(1, 2 * (SET_MAX - cur_set) / (n - i) + 1),
                                SET_MAX);
            if ($urandom_range(0, 9) != 0)
                cur_adc = clamp(cur_adc + $urandom_range(1, 2 * (ADC_MAX - cur_adc) / (n - i) + 1),
                                ADC_MAX);
        end
    endtask

    task automatic query_points(input int n);
        int pick;
        int k;
        int s;
        int a;
        repeat ($urandom_range(10, 30))
        begin
            pick = $urandom_range(0, 9);
            k = (n > 0) ? $urandom_range(0, n - 1) : 0;
            s = $urandom_range(0, SET_MAX);
            a = $urandom_range(0, ADC_MAX);
            case (pick)
                0, 1, 2, 3:
                begin
                    case ($urandom_range(0, 4))
                        0: s = shadow_setting[k];
                        1, 2: s = $urandom_range(shadow_setting[k],
                                                 shadow_setting[(k + 1 < n) ? k + 1 : k]);
                        3: s = clamp((n > 0 && $urandom_range(0, 1)) ?
                                     shadow_setting[n-1] + 1 : shadow_setting[0] - 1, SET_MAX);
                        default: ;
                    endcase
                    send_request(OP_MAP, $urandom_range(0, 15), s, a);
                end
                4, 5:
                begin
                    case ($urandom_range(0, 3))
                        0: a = clamp(shadow_adc[k] + $urandom_range(0, 6) - 3, ADC_MAX);
                        1: a = (shadow_adc[k] + shadow_adc[(k + 1 < n) ? k + 1 : k] +
                                $urandom_range(0, 1)) / 2;
                        default: ;
                    endcase
                    send_request(OP_NEAREST, $urandom_range(0, 15), s, a);
                end
                6:
                    send_request(OP_CALIBRATE, $urandom_range(0, 15),
                                 $urandom_range(0, 2) ? shadow_setting[k] : s, a);
                7:
                    send_request(OP_WRITE, $urandom_range(0, 15), s, a);
                default:
                    send_request(op_t'($urandom_range(0, 3)), $urandom_range(0, 15), s, a);
            endcase
        end
    endtask

    task automatic test_random_tables();
        int count;
        int pick;
        while (requests_sent < REQUEST_TARGET)
        begin
            pick = $urandom_range(0, 19);
            count = (pick == 0) ? 0 :
                    (pick == 1) ? 1 :
                    (pick == 2) ? $urandom_range(17, 31) :
                    (pick == 3) ? POINTS : $urandom_range(2, POINTS);
            load_point_count(count);
            fill_points((count > POINTS) ? POINTS : count);
            query_points((count > POINTS) ? POINTS : count);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            result_stall = 1'b1;
            stall_hold--;
        end
        else
            result_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: mapped_adc %0d nearest_index %0d error %0b adc_in_range %0b",
                             mapped_adc, nearest_index, error, adc_in_range);
            end
            else
            begin
                want_reply = awaited_replies.pop_front();
                if (mapped_adc !== want_reply.mapped || nearest_index !== want_reply.nearest ||
                    error !== want_reply.error || adc_in_range !== want_reply.in_range)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response %0d: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b (mapped_adc/nearest_index/error/adc_in_range)",
                                 replies_checked, want_reply.mapped, want_reply.nearest,
                                 want_reply.error, want_reply.in_range,
                                 mapped_adc, nearest_index, error, adc_in_range);
                end
            end
            if (error === 1'b1)
                error_replies++;
            replies_checked++;
            stall_hold = quiet_stretch ? 0 : $urandom_range(0, 12);
        end
    end

    always @(posedge clk)
    begin
        if ((request_valid && !request_stall) || (result_valid && !result_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        config_write_enable = 1'b0;
        config_write_data = '0;
        request_valid = 1'b0;
        operation = OP_WRITE;
        entry_index = '0;
        setting = '0;
        adc_value = '0;
        result_stall = 1'b0;
        shadow_count = '0;
        for (int i = 0; i < POINTS; i++)
        begin
            shadow_setting[i] = '0;
            shadow_adc[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_table();
        test_directed_points();
        test_random_tables();
        request_valid = 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests over %0d point-count settings: %0d writes, %0d calibrations, %0d maps, %0d nearest",
                 requests_sent, count_settings, op_count[OP_WRITE], op_count[OP_CALIBRATE],
                 op_count[OP_MAP], op_count[OP_NEAREST]);
        $display("%0d responses checked, %0d with error set, %0d mismatches",
                 replies_checked, error_replies, mismatches);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
